/* rtl/baro_temp_press_compensation_defines.svh */
// Assertion macros shared by the compensation RTL.
`ifndef BARO_TEMP_PRESS_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESS_COMPENSATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BTPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BTPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/btpc_pkg.sv */
// Shared types and constants of the barometric compensation block.
`default_nettype none

package btpc_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CfgTemp      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPressLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPressHigh = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPressNine = 2'd3;

  localparam int TempOffset = 128000;
  localparam int PressScale = 3125;
  localparam int PressBase  = 1048576;
  localparam int OffsetShift = 47;
  localparam int P4Shift     = 35;
  localparam int DenShift    = 33;

  localparam int InDataW  = 40;
  localparam int OutDataW = 80;

  // Fields that ride alongside the quotient through the divider.
  typedef struct packed {
    logic signed [15:0] temp;
    logic signed [31:0] fine;
    logic               nz;
  } side_t;

endpackage

`default_nettype wire

/* rtl/btpc_div.sv */
// Pipelined 64-by-31-bit restoring divider, one quotient bit per stage.
`default_nettype none

`include "baro_temp_press_compensation_defines.svh"

module btpc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         in_num,
  input  logic [30:0]         in_den,
  input  logic                in_neg,
  input  btpc_pkg::side_t     in_side,
  output logic                out_valid,
  output logic signed [63:0]  out_quot,
  output btpc_pkg::side_t     out_side
);

  typedef struct packed {
    logic [63:0]     dsh;
    logic [30:0]     rem;
    logic [30:0]     den;
    logic            neg;
    btpc_pkg::side_t side;
  } stage_t;

  stage_t      st [0:64];
  logic [64:0] vld;

  // Shift one dividend bit into the remainder and subtract if it fits.
  function automatic stage_t div_step(input stage_t s);
    logic [31:0] r;
    logic [32:0] diff;
    stage_t      n;
    r    = {s.rem, s.dsh[63]};
    diff = {1'b0, r} - {2'b00, s.den};
    n    = s;
    if (!diff[32]) begin
      n.rem = diff[30:0];
    end else begin
      n.rem = r[30:0];
    end
    n.dsh = {s.dsh[62:0], ~diff[32]};
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[63:0], in_valid};
      out_valid <= vld[64];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].dsh  <= in_num;
      st[0].rem  <= '0;
      st[0].den  <= in_den;
      st[0].neg  <= in_neg;
      st[0].side <= in_side;
      for (int i = 0; i < 64; i++) begin
        st[i+1] <= div_step(st[i]);
      end
      out_quot <= st[64].neg ? -$signed(st[64].dsh) : $signed(st[64].dsh);
      out_side <= st[64].side;
    end
  end

  `BTPC_ASSERT_NOW(a_div_rem, vld[64] && (st[64].den != '0), st[64].rem < st[64].den, "remainder not below divisor")
  `BTPC_ASSERT_NEXT(a_div_hold, !en, $stable(out_valid), "divider output moved during stall")

endmodule

`default_nettype wire

/* rtl/baro_temp_press_compensation.sv */
// Top level of the barometric temperature and pressure compensation pipeline.
`default_nettype none

`include "baro_temp_press_compensation_defines.svh"

// Takes one raw temperature / raw pressure pair per clock while the output
// buffer is not full and returns one result per pair, in order. The sustained
// rate is one pair per cycle when the output side does not stall; the
// latency is set mostly by the 64-stage quotient pipeline of the pressure
// division, with ten stages of calibration arithmetic before it and four
// after. A two-entry output buffer holds finished results; the input stalls
// only while that buffer is full. Calibration registers are written through
// the cfg port and must only change while no request is in flight.
module baro_temp_press_compensation (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [19:0] raw_temperature, [39:20] raw_pressure
  input  logic [btpc_pkg::InDataW-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] temperature_centideg, [47:16] fine_temperature,
  // [79:48] pressure_q24_8
  output logic [btpc_pkg::OutDataW-1:0]  m_tdata,
  // [0] pressure_valid
  output logic [0:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [btpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [btpc_pkg::CfgDataW-1:0]  cfg_wdata
);

  typedef struct packed {
    logic [31:0]        press;
    logic signed [31:0] fine;
    logic signed [15:0] temp;
    logic               pvalid;
  } out_t;

  // Calibration registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [15:0] press_nine;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  always_comb begin
    t1 = temp_coeffs[15:0];
    t2 = $signed(temp_coeffs[31:16]);
    t3 = $signed(temp_coeffs[47:32]);
    p1 = press_low[15:0];
    p2 = $signed(press_low[31:16]);
    p3 = $signed(press_low[47:32]);
    p4 = $signed(press_low[63:48]);
    p5 = $signed(press_high[15:0]);
    p6 = $signed(press_high[31:16]);
    p7 = $signed(press_high[47:32]);
    p8 = $signed(press_high[63:48]);
    p9 = $signed(press_nine);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_low   <= '0;
      press_high  <= '0;
      press_nine  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btpc_pkg::CfgTemp:      temp_coeffs <= cfg_wdata[47:0];
        btpc_pkg::CfgPressLow:  press_low   <= cfg_wdata;
        btpc_pkg::CfgPressHigh: press_high  <= cfg_wdata;
        btpc_pkg::CfgPressNine: press_nine  <= cfg_wdata[15:0];
      endcase
    end
  end

  // Output buffer and pipeline enable
  out_t       obuf [0:1];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       full, en, push, pop;

  assign full     = (count == 2'd2);
  assign en       = ~full;
  assign s_tready = en;

  // Pipeline registers
  logic [9:0] vld;
  logic [3:0] post_vld;

  logic signed [33:0] sa_tprod;
  logic [31:0]        sa_dd;
  logic [19:0]        sa_adcp;
  logic signed [22:0] sb_apart;
  logic signed [36:0] sb_bprod;
  logic [19:0]        sb_adcp;
  logic signed [31:0] sc_fine;
  logic [19:0]        sc_adcp;
  logic signed [15:0] sd_temp;
  logic signed [31:0] sd_fine;
  logic signed [53:0] sd_v1sq;
  logic signed [42:0] sd_v1p5, sd_v1p2;
  logic [19:0]        sd_adcp;
  logic signed [63:0] se_x6, se_x3;
  logic signed [42:0] se_v1p5, se_v1p2;
  logic signed [15:0] se_temp;
  logic signed [31:0] se_fine;
  logic [19:0]        se_adcp;
  logic signed [63:0] sf_v2, sf_w;
  logic signed [15:0] sf_temp;
  logic signed [31:0] sf_fine;
  logic [19:0]        sf_adcp;
  logic [47:0]        sg_wl;
  logic [31:0]        sg_wh;
  logic signed [63:0] sg_v2;
  logic signed [15:0] sg_temp;
  logic signed [31:0] sg_fine;
  logic [19:0]        sg_adcp;
  logic signed [30:0] sh_v1f;
  logic [63:0]        sh_x;
  logic signed [15:0] sh_temp;
  logic signed [31:0] sh_fine;
  logic [63:0]        si_num;
  logic [30:0]        si_den;
  logic               si_dneg, si_nz;
  logic signed [15:0] si_temp;
  logic signed [31:0] si_fine;
  logic [63:0]        sj_num;
  logic [30:0]        sj_den;
  logic               sj_neg;
  btpc_pkg::side_t    sj_side;

  logic               dv_valid;
  logic signed [63:0] dv_q;
  btpc_pkg::side_t    dv_side;

  logic signed [63:0] sk_m1, sk_pb, sk_s, sk_q;
  btpc_pkg::side_t    sk_side;
  logic [63:0]        sl_ll;
  logic [31:0]        sl_c1, sl_c2;
  logic signed [63:0] sl_b, sl_q;
  btpc_pkg::side_t    sl_side;
  logic signed [63:0] sm_a, sm_b, sm_q;
  btpc_pkg::side_t    sm_side;
  logic signed [63:0] sn_sum;
  btpc_pkg::side_t    sn_side;

  // Combinational stage logic
  logic signed [17:0] c_ta;
  logic signed [16:0] c_d;
  logic signed [33:0] c_tprod, c_dd;
  logic signed [36:0] c_bprod;
  logic signed [34:0] c_t5;
  logic signed [34:0] c_ts;
  logic signed [15:0] c_temp;
  logic signed [26:0] c_v1;
  logic signed [53:0] c_v1sq;
  logic signed [42:0] c_v1p5, c_v1p2;
  logic signed [69:0] c_x6f, c_x3f;
  logic signed [63:0] c_v2, c_u, c_w;
  logic [47:0]        c_wl, c_whf;
  logic [63:0]        c_prod, c_x;
  logic [20:0]        c_pd;
  logic [75:0]        c_numf;
  logic [30:0]        c_den;
  logic [63:0]        c_numabs;
  logic signed [63:0] c_s;
  logic signed [79:0] c_m1f, c_pbf;
  logic [63:0]        c_ll, c_c1f, c_c2f;
  logic [31:0]        c_csum;
  logic [63:0]        c_m2;
  logic signed [63:0] c_p;
  out_t               c_out;

  function automatic logic signed [15:0] sat16(input logic signed [34:0] x);
    logic signed [15:0] r;
    if (x > 35'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -35'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  always_comb begin
    // A: temperature products
    c_ta    = $signed({1'b0, s_tdata[19:3]}) - $signed({1'b0, t1, 1'b0});
    c_d     = $signed({1'b0, s_tdata[19:4]}) - $signed({1'b0, t1});
    c_tprod = c_ta * t2;
    c_dd    = c_d * c_d;
    // B
    c_bprod = $signed({1'b0, sa_dd[31:12]}) * t3;
    // D: centidegrees and pressure offset terms
    c_t5    = ($signed({{3{sc_fine[31]}}, sc_fine}) <<< 2)
            + $signed({{3{sc_fine[31]}}, sc_fine}) + 35'sd128;
    c_ts    = c_t5 >>> 8;
    c_temp  = sat16(c_ts);
    c_v1    = 27'(sc_fine) - 27'(btpc_pkg::TempOffset);
    c_v1sq  = c_v1 * c_v1;
    c_v1p5  = c_v1 * p5;
    c_v1p2  = c_v1 * p2;
    // E
    c_x6f   = sd_v1sq * p6;
    c_x3f   = sd_v1sq * p3;
    // F
    c_v2    = se_x6 + (64'(se_v1p5) <<< 17) + (64'(p4) <<< btpc_pkg::P4Shift);
    c_u     = (se_x3 >>> 8) + (64'(se_v1p2) <<< 12);
    c_w     = c_u + (64'sd1 <<< btpc_pkg::OffsetShift);
    // G: low 64 bits of w * P1 as two partial products
    c_wl    = sf_w[31:0] * p1;
    c_whf   = sf_w[63:32] * p1;
    // H
    c_prod  = {16'b0, sg_wl} + {sg_wh, 32'b0};
    c_pd    = 21'(btpc_pkg::PressBase) - {1'b0, sg_adcp};
    c_x     = {12'b0, c_pd, 31'b0} - sg_v2;
    // I
    c_numf  = sh_x * 12'(btpc_pkg::PressScale);
    c_den   = sh_v1f[30] ? 31'(-sh_v1f) : sh_v1f;
    // J
    c_numabs = si_num[63] ? -si_num : si_num;
    // K
    c_s     = dv_q >>> 13;
    c_m1f   = p9 * c_s;
    c_pbf   = p8 * dv_q;
    // L: low 64 bits of m1 * s from three partial products
    c_ll    = sk_m1[31:0] * sk_s[31:0];
    c_c1f   = sk_m1[63:32] * sk_s[31:0];
    c_c2f   = sk_m1[31:0] * sk_s[63:32];
    // M
    c_csum  = sl_c1 + sl_c2;
    c_m2    = sl_ll + {c_csum, 32'b0};
    // N result: rescale, add P7 term, clamp
    c_p          = (sn_sum >>> 8) + (64'(p7) <<< 4);
    c_out.temp   = sn_side.temp;
    c_out.fine   = sn_side.fine;
    c_out.pvalid = sn_side.nz;
    if (!sn_side.nz || c_p[63]) begin
      c_out.press = '0;
    end else if (c_p[62:32] != '0) begin
      c_out.press = '1;
    end else begin
      c_out.press = c_p[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      post_vld <= '0;
    end else if (en) begin
      vld      <= {vld[8:0], s_tvalid};
      post_vld <= {post_vld[2:0], dv_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_tprod <= c_tprod;
      sa_dd    <= c_dd[31:0];
      sa_adcp  <= s_tdata[39:20];

      sb_apart <= 23'(sa_tprod >>> 11);
      sb_bprod <= c_bprod;
      sb_adcp  <= sa_adcp;

      sc_fine  <= 32'(sb_apart) + 32'(sb_bprod >>> 14);
      sc_adcp  <= sb_adcp;

      sd_temp  <= c_temp;
      sd_fine  <= sc_fine;
      sd_v1sq  <= c_v1sq;
      sd_v1p5  <= c_v1p5;
      sd_v1p2  <= c_v1p2;
      sd_adcp  <= sc_adcp;

      se_x6    <= c_x6f[63:0];
      se_x3    <= c_x3f[63:0];
      se_v1p5  <= sd_v1p5;
      se_v1p2  <= sd_v1p2;
      se_temp  <= sd_temp;
      se_fine  <= sd_fine;
      se_adcp  <= sd_adcp;

      sf_v2    <= c_v2;
      sf_w     <= c_w;
      sf_temp  <= se_temp;
      sf_fine  <= se_fine;
      sf_adcp  <= se_adcp;

      sg_wl    <= c_wl;
      sg_wh    <= c_whf[31:0];
      sg_v2    <= sf_v2;
      sg_temp  <= sf_temp;
      sg_fine  <= sf_fine;
      sg_adcp  <= sf_adcp;

      sh_v1f   <= $signed(c_prod[63:33]);
      sh_x     <= c_x;
      sh_temp  <= sg_temp;
      sh_fine  <= sg_fine;

      si_num   <= c_numf[63:0];
      si_den   <= c_den;
      si_dneg  <= sh_v1f[30];
      si_nz    <= (sh_v1f != '0);
      si_temp  <= sh_temp;
      si_fine  <= sh_fine;

      sj_num       <= c_numabs;
      sj_den       <= si_den;
      sj_neg       <= si_num[63] ^ si_dneg;
      sj_side.temp <= si_temp;
      sj_side.fine <= si_fine;
      sj_side.nz   <= si_nz;

      sk_m1   <= c_m1f[63:0];
      sk_pb   <= c_pbf[63:0];
      sk_s    <= c_s;
      sk_q    <= dv_q;
      sk_side <= dv_side;

      sl_ll   <= c_ll;
      sl_c1   <= c_c1f[31:0];
      sl_c2   <= c_c2f[31:0];
      sl_b    <= sk_pb >>> 19;
      sl_q    <= sk_q;
      sl_side <= sk_side;

      sm_a    <= $signed(c_m2) >>> 25;
      sm_b    <= sl_b;
      sm_q    <= sl_q;
      sm_side <= sl_side;

      sn_sum  <= sm_q + sm_a + sm_b;
      sn_side <= sm_side;
    end
  end

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[9]),
    .in_num    (sj_num),
    .in_den    (sj_den),
    .in_neg    (sj_neg),
    .in_side   (sj_side),
    .out_valid (dv_valid),
    .out_quot  (dv_q),
    .out_side  (dv_side)
  );

  // Output buffer: accept finished results while fewer than two wait downstream
  assign push = en & post_vld[3];
  assign pop  = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= c_out;
    end
  end

  assign m_tvalid   = (count != '0);
  assign m_tdata    = {obuf[rd_ptr].press, obuf[rd_ptr].fine, obuf[rd_ptr].temp};
  assign m_tuser[0] = obuf[rd_ptr].pvalid;

  `BTPC_ASSERT_NOW(a_cnt_range, 1'b1, count != 2'd3, "output buffer count out of range")
  `BTPC_ASSERT_NOW(a_inval_zero, m_tvalid && !m_tuser[0], m_tdata[79:48] == '0, "invalid pressure not zero")
  `BTPC_ASSERT_NEXT(a_full_hold, full && !pop, full, "full buffer drained without a pop")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the barometric compensation pipeline.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] temp;
    logic signed [31:0] fine;
    logic        [31:0] press;
    logic               valid;
  } comp_res_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [btpc_pkg::InDataW-1:0] s_tdata;
  logic [btpc_pkg::OutDataW-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we;
  logic [btpc_pkg::CfgIdxW-1:0] cfg_index;
  logic [btpc_pkg::CfgDataW-1:0] cfg_wdata;

  logic [47:0] tcoef;
  logic [63:0] pcoef_lo, pcoef_hi;
  logic [15:0] pcoef_9;
  int errors = 0;
  int quiet_tx = 0, quiet_rx = 0;

  baro_temp_press_compensation dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Truncating divide, most negative / -1 wraps.
  function automatic logic signed [63:0] div_trunc(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    if (a[63] != b[63]) q = -q;
    return q;
  endfunction

  function automatic comp_res_t compensate(input logic [19:0] rt, input logic [19:0] rp);
    logic signed [63:0] adt, adp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, b, d, fine, tmp, v1, v2, p;
    comp_res_t r;
    adt = {44'd0, rt};
    adp = {44'd0, rp};
    t1 = {48'd0, tcoef[15:0]};
    t2 = sx16(tcoef[31:16]);
    t3 = sx16(tcoef[47:32]);
    p1 = {48'd0, pcoef_lo[15:0]};
    p2 = sx16(pcoef_lo[31:16]);
    p3 = sx16(pcoef_lo[47:32]);
    p4 = sx16(pcoef_lo[63:48]);
    p5 = sx16(pcoef_hi[15:0]);
    p6 = sx16(pcoef_hi[31:16]);
    p7 = sx16(pcoef_hi[47:32]);
    p8 = sx16(pcoef_hi[63:48]);
    p9 = sx16(pcoef_9);
    a = (((adt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = (adt >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    if (fine > 64'sd2147483647) fine = 64'sd2147483647;
    if (fine < -64'sd2147483648) fine = -64'sd2147483648;
    tmp = (fine * 5 + 128) >>> 8;
    if (tmp > 64'sd32767) tmp = 64'sd32767;
    if (tmp < -64'sd32768) tmp = -64'sd32768;
    r.temp = tmp[15:0];
    r.fine = fine[31:0];
    v1 = fine - btpc_pkg::TempOffset;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< btpc_pkg::P4Shift);
    v1 = (((v1 * v1 * p3) >>> 8)) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< btpc_pkg::OffsetShift) + v1) * p1) >>> btpc_pkg::DenShift;
    if (v1 == 0) begin
      r.press = '0;
      r.valid = 1'b0;
    end else begin
      p = btpc_pkg::PressBase - adp;
      p = div_trunc(((p <<< 31) - v2) * btpc_pkg::PressScale, v1);
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 <<< 4);
      if (p < 0) r.press = '0;
      else if (p > 64'sd4294967295) r.press = '1;
      else r.press = p[31:0];
      r.valid = 1'b1;
    end
    return r;
  endfunction

  class result_board;
    comp_res_t pending[$];
    function void note(comp_res_t r);
      pending.push_back(r);
    endfunction
    task check(comp_res_t got);
      comp_res_t w;
      if (pending.size() == 0) begin
        report("unrequested result", 64'(got.fine), 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.temp !== w.temp) report("temperature", 64'(got.temp), 64'(w.temp));
      if (got.fine !== w.fine) report("fine temperature", 64'(got.fine), 64'(w.fine));
      if (got.press !== w.press) report("pressure", 64'(got.press), 64'(w.press));
      if (got.valid !== w.valid) report("pressure valid", 64'(got.valid), 64'(w.valid));
    endtask
  endclass

  result_board board = new();

  // Sample outputs at the edge; the receiver stalls at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        board.check('{temp: m_tdata[15:0], fine: m_tdata[47:16],
                      press: m_tdata[79:48], valid: m_tuser[0]});
      m_tready <= quiet_rx > 0 || $urandom_range(99) >= 18;
    end
  end

  task automatic write_reg(input logic [btpc_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      btpc_pkg::CfgTemp: tcoef = val[47:0];
      btpc_pkg::CfgPressLow: pcoef_lo = val;
      btpc_pkg::CfgPressHigh: pcoef_hi = val;
      default: pcoef_9 = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send(input logic [19:0] rt, input logic [19:0] rp);
    while (quiet_tx == 0 && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rp, rt};
    board.note(compensate(rt, rp));
    do @(posedge clk); while (!s_tready);
    if (quiet_tx > 0) quiet_tx--;
  endtask

  // Typical sensor calibration, perturbed.
  task automatic load_typical;
    write_reg(btpc_pkg::CfgTemp,
              64'({16'd50, 16'd26435, 16'd27504 + 16'($urandom_range(4000))}));
    write_reg(btpc_pkg::CfgPressLow, {16'd2855, -16'sd10230,
                                      16'd36477 + 16'($urandom_range(2000)), 16'd36477});
    write_reg(btpc_pkg::CfgPressHigh, {-16'sd12000 + 16'($urandom_range(200)), 16'd15500,
                                       -16'sd7, 16'd140});
    write_reg(btpc_pkg::CfgPressNine, 64'(16'd6000));
  endtask

  task automatic load_random;
    write_reg(btpc_pkg::CfgTemp, {$urandom, $urandom});
    write_reg(btpc_pkg::CfgPressLow, {$urandom, $urandom});
    write_reg(btpc_pkg::CfgPressHigh, {$urandom, $urandom});
    write_reg(btpc_pkg::CfgPressNine, 64'($urandom));
  endtask

  task automatic random_pairs(input int n);
    repeat (n) send(20'($urandom), 20'($urandom));
    s_tvalid <= 1'b0;
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    tcoef = '0; pcoef_lo = '0; pcoef_hi = '0; pcoef_9 = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // All-zero calibration: the divisor is zero.
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    s_tvalid <= 1'b0;
    drain();
    load_typical();
    send(20'd519888, 20'd415148);
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'd0);
    send(20'h80000, 20'h7FFFF);
    s_tvalid <= 1'b0;
    drain();
    // Extreme calibration words.
    write_reg(btpc_pkg::CfgTemp, 64'({16'h7FFF, 16'h7FFF, 16'hFFFF}));
    write_reg(btpc_pkg::CfgPressLow, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
    write_reg(btpc_pkg::CfgPressHigh, {4{16'h7FFF}});
    write_reg(btpc_pkg::CfgPressNine, 64'(16'h8000));
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'h5A5A5, 20'hA5A5A);
    s_tvalid <= 1'b0;
    drain();
    write_reg(btpc_pkg::CfgTemp, 64'({16'h8000, 16'h8000, 16'h0000}));
    write_reg(btpc_pkg::CfgPressLow, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001});
    write_reg(btpc_pkg::CfgPressHigh, {4{16'h8000}});
    write_reg(btpc_pkg::CfgPressNine, 64'(16'h7FFF));
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'd0);
    s_tvalid <= 1'b0;
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) load_typical(); else load_random();
      if (ph == 3) quiet_tx = 150;
      if (ph == 4) quiet_rx = 1;
      random_pairs(200);
      quiet_rx = 0;
      // Hold off until every pending result is back.
      drain();
    end
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire
